[rtl/core/gmd_pkg.sv]
// Shared types and constants for the gradient magnitude/direction core.
// No dependencies; used by every module in rtl/core.
`timescale 1ns / 1ps

package gmd_pkg;

  // Quantized gradient direction
  typedef enum logic [1:0] {
    DIR_HORIZ     = 2'd0,
    DIR_DIAG_SAME = 2'd1,
    DIR_VERT      = 2'd2,
    DIR_DIAG_OPP  = 2'd3
  } dir_e;

  // Saturation level of the 8-bit edge image
  localparam logic [7:0] CLIP_MAX = 8'd255;

endpackage

[rtl/core/gmd_front.sv]
// Front end: absolute values and squares, then sum of squares and direction bin.
// Two registered stages with valid/ready. Depends on gmd_pkg.
`timescale 1ns / 1ps

module gmd_front #(
  parameter int GRAD_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [GRAD_BITS-1:0]   grad_x_i,
  input  logic signed [GRAD_BITS-1:0]   grad_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2*GRAD_BITS-1:0]        out_sum_o,
  output gmd_pkg::dir_e                 out_dir_o
);

  localparam int SqBits = 2 * GRAD_BITS;

  logic [GRAD_BITS-1:0] abs_x, abs_y;

  logic                 v1_q;
  logic [GRAD_BITS-1:0] a_q, b_q;
  logic [SqBits-1:0]    aa_q, bb_q, ab2_q;
  logic                 same_sign_q;

  logic                 v2_q;
  logic [SqBits-1:0]    sum_q;
  gmd_pkg::dir_e        dir_q, dir_d;

  logic                 rdy1, rdy2;

  assign rdy2       = !v2_q || out_ready_i;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // Two's complement negation wraps the most negative value onto 2^(N-1)
  assign abs_x = grad_x_i[GRAD_BITS-1] ? (~grad_x_i + 1'b1) : grad_x_i;
  assign abs_y = grad_y_i[GRAD_BITS-1] ? (~grad_y_i + 1'b1) : grad_y_i;

  // Tangent tests: b < tan22.5*a  <=>  b*b + 2ab < a*a, and the mirror for 67.5
  always_comb begin
    if (a_q == '0 && b_q == '0) begin
      dir_d = gmd_pkg::DIR_HORIZ;
    end else if (bb_q + ab2_q < aa_q) begin
      dir_d = gmd_pkg::DIR_HORIZ;
    end else if (aa_q + ab2_q < bb_q) begin
      dir_d = gmd_pkg::DIR_VERT;
    end else if (same_sign_q) begin
      dir_d = gmd_pkg::DIR_DIAG_SAME;
    end else begin
      dir_d = gmd_pkg::DIR_DIAG_OPP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy1) begin
      a_q         <= abs_x;
      b_q         <= abs_y;
      aa_q        <= SqBits'(abs_x) * SqBits'(abs_x);
      bb_q        <= SqBits'(abs_y) * SqBits'(abs_y);
      ab2_q       <= (SqBits'(abs_x) * SqBits'(abs_y)) << 1;
      same_sign_q <= (grad_x_i[GRAD_BITS-1] == grad_y_i[GRAD_BITS-1]);
    end
    if (v1_q && rdy2) begin
      sum_q <= aa_q + bb_q;
      dir_q <= dir_d;
    end
  end

  assign out_valid_o = v2_q;
  assign out_sum_o   = sum_q;
  assign out_dir_o   = dir_q;

endmodule

[rtl/core/gmd_sqrt_cell.sv]
// One cell of the square-root chain: decides one root bit and passes the word on.
// Restoring digit recurrence on the partial remainder. Depends on gmd_pkg.
`timescale 1ns / 1ps

module gmd_sqrt_cell #(
  parameter int GRAD_BITS = 12,
  parameter int BIT       = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [2*GRAD_BITS-1:0] in_rem_i,
  input  logic [GRAD_BITS-1:0]   in_root_i,
  input  gmd_pkg::dir_e          in_dir_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [2*GRAD_BITS-1:0] out_rem_o,
  output logic [GRAD_BITS-1:0]   out_root_o,
  output gmd_pkg::dir_e          out_dir_o
);

  localparam int RemBits   = 2 * GRAD_BITS;
  localparam int TrialBits = RemBits + 1;

  logic                 valid_q;
  logic [RemBits-1:0]   rem_q, rem_d;
  logic [GRAD_BITS-1:0] root_q, root_d;
  gmd_pkg::dir_e        dir_q;

  logic [TrialBits-1:0] trial;
  logic                 take;

  assign in_ready_o = !valid_q || out_ready_i;

  // (2r + 2^i) * 2^i, with r holding only bits above i
  assign trial = (TrialBits'(in_root_i) << (BIT + 1)) + (TrialBits'(1) << (2 * BIT));
  assign take  = ({1'b0, in_rem_i} >= trial);

  always_comb begin
    rem_d  = in_rem_i;
    root_d = in_root_i;
    if (take) begin
      rem_d  = in_rem_i - trial[RemBits-1:0];
      root_d = in_root_i | (GRAD_BITS'(1) << BIT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      dir_q  <= in_dir_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_rem_o   = rem_q;
  assign out_root_o  = root_q;
  assign out_dir_o   = dir_q;

endmodule

[rtl/core/gradient_magnitude_direction_core.sv]
// Pipeline from input word to output word: two front stages, one square-root cell per
// magnitude bit, one output register.
// Throughput: one word per cycle; each stage stalls only when its successor is full.
// Reset: rst_ni asynchronous, active low, empties every stage; data registers keep no reset.
// Top level: front end, chain of square-root cells, output register. Depends on gmd_pkg,
// gmd_front and gmd_sqrt_cell.
`timescale 1ns / 1ps

module gradient_magnitude_direction_core #(
  parameter int GRAD_BITS = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [GRAD_BITS-1:0] grad_x_i,
  input  logic signed [GRAD_BITS-1:0] grad_y_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [GRAD_BITS-1:0]        magnitude_o,
  output logic [7:0]                  magnitude_clipped_o,
  output logic [1:0]                  direction_o
);

  localparam int RemBits = 2 * GRAD_BITS;
  localparam int ExtBits = (GRAD_BITS > 9) ? GRAD_BITS : 9;

  logic                 chain_valid [0:GRAD_BITS];
  logic                 chain_ready [0:GRAD_BITS];
  logic [RemBits-1:0]   chain_rem   [0:GRAD_BITS];
  logic [GRAD_BITS-1:0] chain_root  [0:GRAD_BITS];
  gmd_pkg::dir_e        chain_dir   [0:GRAD_BITS];

  logic                 out_valid_q;
  logic [GRAD_BITS-1:0] mag_q;
  logic [7:0]           clip_q;
  gmd_pkg::dir_e        dir_q;

  logic [ExtBits-1:0]   mag_ext;
  logic [7:0]           clip_d;

  gmd_front #(
    .GRAD_BITS (GRAD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .grad_x_i    (grad_x_i),
    .grad_y_i    (grad_y_i),
    .out_valid_o (chain_valid[0]),
    .out_ready_i (chain_ready[0]),
    .out_sum_o   (chain_rem[0]),
    .out_dir_o   (chain_dir[0])
  );

  assign chain_root[0] = '0;

  // Cell k settles root bit GRAD_BITS-1-k, most significant first
  for (genvar k = 0; k < GRAD_BITS; k++) begin : g_cell
    gmd_sqrt_cell #(
      .GRAD_BITS (GRAD_BITS),
      .BIT       (GRAD_BITS - 1 - k)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (chain_valid[k]),
      .in_ready_o  (chain_ready[k]),
      .in_rem_i    (chain_rem[k]),
      .in_root_i   (chain_root[k]),
      .in_dir_i    (chain_dir[k]),
      .out_valid_o (chain_valid[k+1]),
      .out_ready_i (chain_ready[k+1]),
      .out_rem_o   (chain_rem[k+1]),
      .out_root_o  (chain_root[k+1]),
      .out_dir_o   (chain_dir[k+1])
    );
  end

  assign chain_ready[GRAD_BITS] = !out_valid_q || out_ready_i;

  // Saturate for the 8-bit edge image
  assign mag_ext = ExtBits'(chain_root[GRAD_BITS]);
  assign clip_d  = (mag_ext > ExtBits'(gmd_pkg::CLIP_MAX)) ? gmd_pkg::CLIP_MAX : mag_ext[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (chain_ready[GRAD_BITS]) begin
      out_valid_q <= chain_valid[GRAD_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (chain_valid[GRAD_BITS] && chain_ready[GRAD_BITS]) begin
      mag_q  <= chain_root[GRAD_BITS];
      clip_q <= clip_d;
      dir_q  <= chain_dir[GRAD_BITS];
    end
  end

  assign out_valid_o         = out_valid_q;
  assign magnitude_o         = mag_q;
  assign magnitude_clipped_o = clip_q;
  assign direction_o         = dir_q;

endmodule

[rtl/core/gmd_checker.sv]
// Port-level checker for gradient_magnitude_direction_core, bound to the top level.
// Sees the top-level ports only. Depends on gmd_pkg.
`timescale 1ns / 1ps

module gmd_checker #(
  parameter int GRAD_BITS = 12
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic signed [GRAD_BITS-1:0] grad_x_i,
  input logic signed [GRAD_BITS-1:0] grad_y_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [GRAD_BITS-1:0]        magnitude_o,
  input logic [7:0]                  magnitude_clipped_o,
  input logic [1:0]                  direction_o
);

  localparam int ExtBits = (GRAD_BITS > 9) ? GRAD_BITS : 9;

  logic [ExtBits-1:0] mag_ext;
  logic [7:0]         clip_exp;

  assign mag_ext  = ExtBits'(magnitude_o);
  assign clip_exp = (mag_ext > ExtBits'(gmd_pkg::CLIP_MAX)) ? gmd_pkg::CLIP_MAX : mag_ext[7:0];

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(magnitude_o)
      && $stable(magnitude_clipped_o) && $stable(direction_o))
    else $error("output word changed while stalled");

  // Input back-pressure only comes from a full pipe behind a stalled output
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while output side drains");

  a_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> magnitude_clipped_o == clip_exp)
    else $error("clipped magnitude disagrees with magnitude");

  // Zero magnitude only from a zero gradient, which is horizontal
  a_zero_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && magnitude_o == '0 |-> direction_o == gmd_pkg::DIR_HORIZ)
    else $error("zero gradient not in horizontal bin");

endmodule

bind gradient_magnitude_direction_core gmd_checker #(.GRAD_BITS(GRAD_BITS)) u_gmd_checker (.*);

[test/gradient_magnitude_direction_core_tb.sv]
// Self-checking bench for gradient_magnitude_direction_core: an exact integer predictor
// scores every output word against the gradients that were accepted, in order.
// Depends on gmd_pkg and the core RTL only.
`timescale 1ns / 1ps

module gradient_magnitude_direction_core_tb;

  localparam int GB         = 12;
  localparam int LATENCY    = GB + 3;
  localparam int N_RANDOM   = 850;
  localparam int CYCLE_CAP  = 60000;
  localparam int IDLE_PCT   = 28;
  localparam int HOLD_AT    = 300;
  localparam int HOLD_LEN   = 250;
  localparam int CALM_FROM  = 500;
  localparam int CALM_TO    = 650;

  typedef struct packed {
    logic signed [GB-1:0] gx;
    logic signed [GB-1:0] gy;
  } grad_word_t;

  typedef struct packed {
    logic [GB-1:0]  mag;
    logic [7:0]     clip;
    gmd_pkg::dir_e  dir;
  } edge_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic signed [GB-1:0] grad_x_i;
  logic signed [GB-1:0] grad_y_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [GB-1:0]        magnitude_o;
  logic [7:0]           magnitude_clipped_o;
  logic [1:0]           direction_o;

  grad_word_t   pixel_q[$];
  edge_result_t edge_expect_q[$];
  int           err_count   = 0;
  int           in_accepted = 0;
  int           cycle_count = 0;
  logic         in_fire     = 1'b0;
  logic         hold_off;
  logic         idle_ok;

  gradient_magnitude_direction_core #(
    .GRAD_BITS(GB)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .grad_x_i           (grad_x_i),
    .grad_y_i           (grad_y_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .magnitude_o        (magnitude_o),
    .magnitude_clipped_o(magnitude_clipped_o),
    .direction_o        (direction_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Floor square root and direction bin, both from exact integer compares
  function automatic edge_result_t predict_edge(logic signed [GB-1:0] gx,
                                                logic signed [GB-1:0] gy);
    longint       sx, sy, ax, ay, sq, root, trial;
    int           bit_idx;
    edge_result_t r;
    sx = gx;
    sy = gy;
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;
    sq = ax * ax + ay * ay;
    root = 0;
    for (bit_idx = GB; bit_idx >= 0; bit_idx--) begin
      trial = root | (longint'(1) << bit_idx);
      if (trial * trial <= sq) root = trial;
    end
    r.mag  = root[GB-1:0];
    r.clip = (root > longint'(gmd_pkg::CLIP_MAX)) ? gmd_pkg::CLIP_MAX : root[7:0];
    if (ax == 0 && ay == 0) r.dir = gmd_pkg::DIR_HORIZ;
    else if (ay * ay + 2 * ax * ay < ax * ax) r.dir = gmd_pkg::DIR_HORIZ;
    else if (ax * ax + 2 * ax * ay < ay * ay) r.dir = gmd_pkg::DIR_VERT;
    else if ((sx < 0) == (sy < 0)) r.dir = gmd_pkg::DIR_DIAG_SAME;
    else r.dir = gmd_pkg::DIR_DIAG_OPP;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] ERROR %s: got %0d, want %0d", $time, what, got, want);
    err_count++;
  endtask

  task automatic add_pixel(int x, int y);
    grad_word_t w;
    w.gx = x[GB-1:0];
    w.gy = y[GB-1:0];
    pixel_q.push_back(w);
  endtask

  // Input side: predict on acceptance; output side: score against the oldest prediction
  always @(posedge clk_i) begin : monitor
    edge_result_t want;
    cycle_count <= cycle_count + 1;
    in_fire <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        edge_expect_q.push_back(predict_edge(grad_x_i, grad_y_i));
        in_accepted <= in_accepted + 1;
      end
      if (out_valid_o && out_ready_i) begin
        if (edge_expect_q.size() == 0) begin
          report_mismatch("output word with nothing pending", int'(magnitude_o), 0);
        end else begin
          want = edge_expect_q.pop_front();
          if (magnitude_o != want.mag)
            report_mismatch("magnitude", int'(magnitude_o), int'(want.mag));
          if (magnitude_clipped_o != want.clip)
            report_mismatch("magnitude_clipped", int'(magnitude_clipped_o),
                            int'(want.clip));
          if (direction_o != want.dir)
            report_mismatch("direction", int'(direction_o), int'(want.dir));
        end
      end
    end
  end

  // Steady stretch with no idling on either side
  assign idle_ok = !(in_accepted >= CALM_FROM && in_accepted < CALM_TO);

  always @(negedge clk_i) begin : driver
    grad_word_t w;
    if (rst_ni) begin
      if (!in_valid_i || in_fire) begin
        if (pixel_q.size() != 0 && !(idle_ok && $urandom_range(99) < IDLE_PCT)) begin
          w = pixel_q.pop_front();
          grad_x_i   <= w.gx;
          grad_y_i   <= w.gy;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni)
      out_ready_i <= !hold_off && !(idle_ok && $urandom_range(99) < IDLE_PCT);
  end

  // Stall the receiver long enough to fill the pipeline and back up the input
  initial begin
    hold_off = 1'b0;
    while (in_accepted < HOLD_AT) @(negedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_LEN) @(negedge clk_i);
    hold_off <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (cycle_count > CYCLE_CAP) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int mode, x, y, a, b;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    out_ready_i = 1'b0;
    grad_x_i    = '0;
    grad_y_i    = '0;

    // Zero, axis and corner extremes, unit steps in all quadrants
    add_pixel(0, 0);
    add_pixel(2047, 0);
    add_pixel(-2048, 0);
    add_pixel(0, 2047);
    add_pixel(0, -2048);
    add_pixel(2047, 2047);
    add_pixel(-2048, -2048);
    add_pixel(2047, -2048);
    add_pixel(-2048, 2047);
    add_pixel(1, 0);
    add_pixel(0, 1);
    add_pixel(1, 1);
    add_pixel(-1, 1);
    add_pixel(1, -1);
    add_pixel(-1, -1);
    // Pairs just either side of the 22.5 and 67.5 degree boundaries
    add_pixel(12, 5);
    add_pixel(-5, 12);
    add_pixel(29, -12);
    add_pixel(-12, -29);
    // Around the clip level
    add_pixel(255, 0);
    add_pixel(0, -256);
    add_pixel(180, 180);
    add_pixel(-181, 181);
    add_pixel(-170, 191);

    for (int i = 0; i < N_RANDOM; i++) begin
      mode = $urandom_range(9);
      if (mode <= 4) begin
        x = $urandom;
        y = $urandom;
      end else if (mode <= 7) begin
        x = $urandom_range(600) - 300;
        y = $urandom_range(600) - 300;
      end else if (mode == 8) begin
        // one axis at zero or an extreme
        x = $urandom_range(1) ? 0 : ($urandom_range(1) ? 2047 : -2048);
        y = $urandom;
      end else begin
        // hug a direction boundary, either orientation
        a = $urandom_range(2047);
        b = (a * 41421) / 100000 + $urandom_range(2) - 1;
        if (b < 0) b = 0;
        if ($urandom_range(1)) begin x = a; y = b; end
        else begin x = b; y = a; end
        if ($urandom_range(1)) x = -x;
        if ($urandom_range(1)) y = -y;
      end
      if ($urandom_range(1)) add_pixel(x, y);
      else add_pixel(y, x);
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pixel_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (edge_expect_q.size() != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);

    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
